// ----- sv/barometric_pressure_compensation_macros.svh -----
// Assertion macros for the barometric pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BPC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define BPC_ASSERT(label, clk, rst_n, prop)
`define BPC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- sv/bpc_pkg.sv -----
// Types and constants shared by the barometric pressure compensation modules
package bpc_pkg;

    localparam int DIV_W      = 32;
    localparam int DEN_W      = 18;
    localparam int DIV_STAGES = DIV_W;

    localparam logic [31:0] P_SCALE = 32'd50000;

    typedef enum logic [2:0] {
        REG_AC1_AC2      = 3'd0,
        REG_AC3_AC4      = 3'd1,
        REG_AC5_AC6      = 3'd2,
        REG_B1_B2        = 3'd3,
        REG_MC_MD        = 3'd4,
        REG_OVERSAMPLING = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [19:0]        pressure_pa;
        logic               div_error;
    } result_t;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } coeff_t;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic signed [27:0] b5;
        logic [18:0]        up;
    } temp_out_t;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic signed [15:0] t;
        logic [31:0]        b7;
        logic [16:0]        b4;
    } coef_out_t;

endpackage

// ----- sv/barometric_pressure_compensation.sv -----
// Barometric pressure compensation top level: configuration registers and pipeline
// Takes one raw temperature/pressure request per cycle and returns the compensated
// temperature (0.1 degree) and pressure (Pa), one result per cycle. The depth is set by
// two 32-stage restoring dividers, MC/(X1+MD) and B7/B4, in series with the multiply
// stages around them. A stall on the result side holds the whole pipeline and is passed
// back on sample_stall. The user must write coefficients and oversampling through the
// cfg port (always ready) only while no request is in flight; nothing in the block enforces it.
`include "barometric_pressure_compensation_macros.svh"
module barometric_pressure_compensation (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  bpc_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output bpc_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import bpc_pkg::*;

    logic [31:0] ac1_ac2_reg;
    logic [31:0] ac3_ac4_reg;
    logic [31:0] ac5_ac6_reg;
    logic [31:0] b1_b2_reg;
    logic [31:0] mc_md_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= '0;
            ac3_ac4_reg <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AC1_AC2:      ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4:      ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6:      ac5_ac6_reg <= cfg_data;
                REG_B1_B2:        b1_b2_reg   <= cfg_data;
                REG_MC_MD:        mc_md_reg   <= cfg_data;
                REG_OVERSAMPLING: oss_reg     <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    coeff_t coeff;

    assign coeff.ac1 = $signed(ac1_ac2_reg[31:16]);
    assign coeff.ac2 = $signed(ac1_ac2_reg[15:0]);
    assign coeff.ac3 = $signed(ac3_ac4_reg[31:16]);
    assign coeff.ac4 = ac3_ac4_reg[15:0];
    assign coeff.ac5 = ac5_ac6_reg[31:16];
    assign coeff.ac6 = ac5_ac6_reg[15:0];
    assign coeff.b1  = $signed(b1_b2_reg[31:16]);
    assign coeff.b2  = $signed(b1_b2_reg[15:0]);
    assign coeff.mc  = $signed(mc_md_reg[31:16]);
    assign coeff.md  = $signed(mc_md_reg[15:0]);
    assign coeff.oss = oss_reg;

    logic      en;
    temp_out_t tout;
    coef_out_t cout;

    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;
    assign cfg_ready    = 1'b1;

    bpc_temp u_temp (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .sample_valid (sample_valid),
        .sample       (sample),
        .coeff        (coeff),
        .tout         (tout)
    );

    bpc_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .tin   (tout),
        .coeff (coeff),
        .cout  (cout)
    );

    bpc_pres u_pres (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cin          (cout),
        .result_valid (result_valid),
        .result       (result)
    );

    `BPC_ASSERT(a_err_zero, clk, rst_n, result_valid && result.div_error |-> result.temperature_tenths == 0 && result.pressure_pa == 0)
    `BPC_ASSERT_NEVER(a_stall_idle, clk, rst_n, !result_valid && sample_stall)
    `BPC_ASSERT(a_oss_write, clk, rst_n, cfg_valid && cfg_index == REG_OVERSAMPLING |=> oss_reg == $past(cfg_data[1:0]))

endmodule

// ----- sv/bpc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage
module bpc_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [bpc_pkg::DIV_W-1:0]   dividend,
    input  logic [bpc_pkg::DEN_W-1:0]   divisor,
    output logic [bpc_pkg::DIV_W-1:0]   quotient
);
    import bpc_pkg::*;

    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0] word_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DIV_W-1:0] word_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [DIV_W-1:0] word_next;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign den_in  = divisor;
            assign word_in = dividend;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign word_in = word_reg[i-1];
        end

        assign trial     = {rem_in, word_in[DIV_W-1]};
        assign ge        = trial >= {1'b0, den_in};
        assign rem_next  = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign word_next = {word_in[DIV_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                word_reg[i] <= word_next;
            end
        end
    end

    assign quotient = word_reg[DIV_STAGES-1];

endmodule

// ----- sv/bpc_temp.sv -----
// Temperature path: X1 product, MC/(X1+MD) division and B5
module bpc_temp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               sample_valid,
    input  bpc_pkg::sample_t   sample,
    input  bpc_pkg::coeff_t    coeff,
    output bpc_pkg::temp_out_t tout
);
    import bpc_pkg::*;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic               neg;
        logic signed [18:0] x1;
        logic [18:0]        up;
    } tside_t;

    // stage 1
    logic signed [16:0] diff;
    logic signed [33:0] prod_next;
    logic               s1_valid_reg;
    logic signed [33:0] s1_prod_reg;
    logic [18:0]        s1_up_reg;

    assign diff      = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coeff.ac6});
    assign prod_next = diff * $signed({1'b0, coeff.ac5});

    // stage 2
    logic signed [18:0] x1_sh;
    logic               x1_fix;
    logic signed [18:0] x1_next;
    logic signed [18:0] den_next;
    logic               s2_valid_reg;
    logic signed [18:0] s2_x1_reg;
    logic signed [18:0] s2_den_reg;
    logic [18:0]        s2_up_reg;

    assign x1_sh    = 19'(s1_prod_reg >>> 15);
    assign x1_fix   = s1_prod_reg[33] && (s1_prod_reg[14:0] != '0);
    assign x1_next  = x1_sh + $signed({18'b0, x1_fix});
    assign den_next = x1_next + 19'(coeff.md);

    // divider feed
    logic signed [16:0] mc_ext;
    logic [16:0]        mc_mag;
    logic [DEN_W-1:0]   den_mag;
    logic [DIV_W-1:0]   quotient;
    tside_t             side_in;
    tside_t             side_reg [DIV_STAGES];

    assign mc_ext  = 17'(coeff.mc);
    assign mc_mag  = mc_ext[16] ? 17'(-mc_ext) : 17'(mc_ext);
    assign den_mag = s2_den_reg[18] ? DEN_W'(-s2_den_reg) : s2_den_reg[DEN_W-1:0];

    assign side_in.valid = s2_valid_reg;
    assign side_in.err   = s2_den_reg == '0;
    assign side_in.neg   = s2_den_reg[18] ^ coeff.mc[15];
    assign side_in.x1    = s2_x1_reg;
    assign side_in.up    = s2_up_reg;

    bpc_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend ({4'b0, mc_mag, 11'b0}),
        .divisor  (den_mag),
        .quotient (quotient)
    );

    // B5
    tside_t             side_out;
    logic signed [27:0] q_s;
    logic signed [27:0] x2;
    temp_out_t          tout_next;
    temp_out_t          tout_reg;

    assign side_out        = side_reg[DIV_STAGES-1];
    assign q_s             = $signed({1'b0, quotient[26:0]});
    assign x2              = side_out.neg ? -q_s : q_s;
    assign tout_next.valid = side_out.valid;
    assign tout_next.err   = side_out.err;
    assign tout_next.b5    = x2 + 28'(side_out.x1);
    assign tout_next.up    = side_out.up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                side_reg[i] <= '0;
            tout_reg <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
            side_reg[0]  <= side_in;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
            tout_reg <= tout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= prod_next;
            s1_up_reg   <= sample.raw_pressure;
            s2_x1_reg   <= x1_next;
            s2_den_reg  <= den_next;
            s2_up_reg   <= s1_up_reg;
        end
    end

    assign tout = tout_reg;

endmodule

// ----- sv/bpc_coef.sv -----
// Pressure coefficient path: temperature, B6 products, B3, B4 and B7
module bpc_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  bpc_pkg::temp_out_t tin,
    input  bpc_pkg::coeff_t    coeff,
    output bpc_pkg::coef_out_t cout
);
    import bpc_pkg::*;

    logic [4:0] valid_reg;
    logic [4:0] err_reg;
    logic signed [15:0] t_reg  [5];
    logic [18:0]        up_reg [5];

    // P1: temperature and B6
    logic signed [27:0] tr;
    logic signed [23:0] t_wide;
    logic signed [15:0] t_next;
    logic signed [27:0] b6_next;
    logic signed [27:0] p1_b6_reg;

    assign tr      = tin.b5 + 28'sd8;
    assign t_wide  = 24'(tr >>> 4) + $signed({23'b0, tr[27] && (tr[3:0] != '0)});
    assign b6_next = tin.b5 - 28'sd4000;

    always_comb
    begin
        if (t_wide > 24'sd32767)
            t_next = 16'sh7fff;
        else if (t_wide < -24'sd32768)
            t_next = -16'sh8000;
        else
            t_next = t_wide[15:0];
    end

    // P2: products of B6
    logic signed [55:0] sq_next;
    logic signed [43:0] ac2b6_next;
    logic signed [43:0] ac3b6_next;
    logic signed [55:0] p2_sq_reg;
    logic signed [43:0] p2_ac2b6_reg;
    logic signed [43:0] p2_ac3b6_reg;

    assign sq_next    = p1_b6_reg * p1_b6_reg;
    assign ac2b6_next = coeff.ac2 * p1_b6_reg;
    assign ac3b6_next = coeff.ac3 * p1_b6_reg;

    // P3: B1, B2 times B6 squared, in two halves
    logic [43:0]        b6sq;
    logic signed [22:0] sq_lo;
    logic signed [22:0] sq_hi;
    logic signed [38:0] p3_b2lo_reg;
    logic signed [38:0] p3_b2hi_reg;
    logic signed [38:0] p3_b1lo_reg;
    logic signed [38:0] p3_b1hi_reg;
    logic signed [43:0] p3_ac2b6_reg;
    logic signed [43:0] p3_ac3b6_reg;

    assign b6sq  = p2_sq_reg[55:12];
    assign sq_lo = $signed({1'b0, b6sq[21:0]});
    assign sq_hi = $signed({1'b0, b6sq[43:22]});

    // P4: X3 sums
    logic signed [61:0] b2full;
    logic signed [61:0] b1full;
    logic signed [50:0] x1a;
    logic signed [32:0] x2a;
    logic signed [51:0] x3a_next;
    logic signed [45:0] x1b;
    logic signed [30:0] x2b;
    logic signed [46:0] sumb;
    logic [31:0]        m32_next;
    logic signed [51:0] p4_x3a_reg;
    logic [31:0]        p4_m32_reg;

    assign b2full   = $signed({p3_b2hi_reg, 22'b0}) + 62'(p3_b2lo_reg);
    assign b1full   = $signed({p3_b1hi_reg, 22'b0}) + 62'(p3_b1lo_reg);
    assign x1a      = 51'(b2full >>> 11);
    assign x2a      = 33'(p3_ac2b6_reg >>> 11);
    assign x3a_next = 52'(x1a) + 52'(x2a);
    assign x1b      = 46'(b1full >>> 16);
    assign x2b      = 31'(p3_ac3b6_reg >>> 13);
    assign sumb     = 47'(x1b) + 47'(x2b) + 47'sd2;
    assign m32_next = sumb[33:2] + 32'd32768;

    // P5: B3 and B4 product
    logic signed [52:0] a_sum;
    logic signed [55:0] v_sh;
    logic signed [55:0] v2;
    logic [31:0]        b3lo_next;
    logic [31:0]        b4prod_next;
    logic [31:0]        p5_b3lo_reg;
    logic [31:0]        p5_b4prod_reg;

    assign a_sum       = (53'(coeff.ac1) <<< 2) + 53'(p4_x3a_reg);
    assign v_sh        = 56'(a_sum) <<< coeff.oss;
    assign v2          = v_sh + 56'sd2;
    assign b3lo_next   = v2[33:2] + {31'b0, v2[55] && (v2[1:0] != '0)};
    assign b4prod_next = p4_m32_reg * {16'b0, coeff.ac4};

    // P6: B4 and B7
    logic [16:0] b4;
    logic [31:0] b7diff;
    logic [15:0] mulc;
    coef_out_t   cout_next;
    coef_out_t   cout_reg;

    assign b4              = p5_b4prod_reg[31:15];
    assign b7diff          = {13'b0, up_reg[4]} - p5_b3lo_reg;
    assign mulc            = 16'(P_SCALE >> coeff.oss);
    assign cout_next.valid = valid_reg[4];
    assign cout_next.err   = err_reg[4] || (b4 == '0);
    assign cout_next.t     = t_reg[4];
    assign cout_next.b7    = b7diff * {16'b0, mulc};
    assign cout_next.b4    = b4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cout_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], tin.valid};
            cout_reg  <= cout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg   <= {err_reg[3:0], tin.err};
            t_reg[0]  <= t_next;
            up_reg[0] <= tin.up;
            for (int i = 1; i < 5; i++)
            begin
                t_reg[i]  <= t_reg[i-1];
                up_reg[i] <= up_reg[i-1];
            end
            p1_b6_reg     <= b6_next;
            p2_sq_reg     <= sq_next;
            p2_ac2b6_reg  <= ac2b6_next;
            p2_ac3b6_reg  <= ac3b6_next;
            p3_b2lo_reg   <= coeff.b2 * sq_lo;
            p3_b2hi_reg   <= coeff.b2 * sq_hi;
            p3_b1lo_reg   <= coeff.b1 * sq_lo;
            p3_b1hi_reg   <= coeff.b1 * sq_hi;
            p3_ac2b6_reg  <= p2_ac2b6_reg;
            p3_ac3b6_reg  <= p2_ac3b6_reg;
            p4_x3a_reg    <= x3a_next;
            p4_m32_reg    <= m32_next;
            p5_b3lo_reg   <= b3lo_next;
            p5_b4prod_reg <= b4prod_next;
        end
    end

    assign cout = cout_reg;

endmodule

// ----- sv/bpc_pres.sv -----
// Pressure path: B7/B4 division, final correction, clamping and output register
module bpc_pres (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  bpc_pkg::coef_out_t cin,
    output logic               result_valid,
    output bpc_pkg::result_t   result
);
    import bpc_pkg::*;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic               half;
        logic signed [15:0] t;
    } pside_t;

    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] quotient;
    pside_t           side_in;
    pside_t           side_reg [DIV_STAGES];

    assign dividend      = cin.b7[31] ? cin.b7 : {cin.b7[30:0], 1'b0};
    assign side_in.valid = cin.valid;
    assign side_in.err   = cin.err;
    assign side_in.half  = cin.b7[31];
    assign side_in.t     = cin.t;

    bpc_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (dividend),
        .divisor  ({1'b0, cin.b4}),
        .quotient (quotient)
    );

    // F1
    pside_t      side_out;
    logic [32:0] p_next;
    logic [24:0] px;
    pside_t      f1_side_reg;
    logic [32:0] f1_p_reg;
    logic [49:0] f1_sq_reg;
    logic [45:0] f1_m2_reg;

    assign side_out = side_reg[DIV_STAGES-1];
    assign p_next   = side_out.half ? {quotient, 1'b0} : {1'b0, quotient};
    assign px       = p_next[32:8];

    // F2
    pside_t      f2_side_reg;
    logic [32:0] f2_p_reg;
    logic [61:0] f2_m1_reg;
    logic [45:0] f2_m2_reg;

    // F3
    logic [45:0]        x1;
    logic [30:0]        x2mag;
    logic signed [47:0] s;
    pside_t             f3_side_reg;
    logic [32:0]        f3_p_reg;
    logic signed [43:0] f3_corr_reg;

    assign x1    = f2_m1_reg[61:16];
    assign x2mag = 31'((47'(f2_m2_reg) + 47'd65535) >> 16);
    assign s     = $signed({2'b0, x1}) - $signed({17'b0, x2mag}) + 48'sd3791;

    // F4
    logic signed [45:0] pr;
    logic [19:0]        pr_sat;
    result_t            result_next;
    logic               result_valid_reg;
    result_t            result_reg;

    assign pr = $signed({13'b0, f3_p_reg}) + 46'(f3_corr_reg);

    always_comb
    begin
        if (pr < 46'sd0)
            pr_sat = '0;
        else if (pr > 46'sd1048575)
            pr_sat = '1;
        else
            pr_sat = pr[19:0];
        result_next.div_error          = f3_side_reg.err;
        result_next.temperature_tenths = f3_side_reg.err ? '0 : f3_side_reg.t;
        result_next.pressure_pa        = f3_side_reg.err ? '0 : pr_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                side_reg[i] <= '0;
            f1_side_reg      <= '0;
            f2_side_reg      <= '0;
            f3_side_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
            f1_side_reg      <= side_out;
            f2_side_reg      <= f1_side_reg;
            f3_side_reg      <= f2_side_reg;
            result_valid_reg <= f3_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_p_reg    <= p_next;
            f1_sq_reg   <= px * px;
            f1_m2_reg   <= p_next * 13'd7357;
            f2_p_reg    <= f1_p_reg;
            f2_m1_reg   <= f1_sq_reg * 12'd3038;
            f2_m2_reg   <= f1_m2_reg;
            f3_p_reg    <= f2_p_reg;
            f3_corr_reg <= 44'(s >>> 4);
            result_reg  <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- dv/barometric_pressure_compensation_test.sv -----
// Self-checking testbench for the barometric pressure compensation block
module barometric_pressure_compensation_test;
    import bpc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    barometric_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [31:0] coeff_word [0:5];
    sample_t     pending_samples [$];
    result_t     expected_results [$];
    int          fail_count;
    int          checked_count;
    int          error_count;
    int          cycle_count;
    int          hold_off_cycles;
    bit          stimulus_done;
    bit          cfg_busy;
    cfg_reg_t    cfg_reg_next;
    logic [31:0] cfg_data_next;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic result_t compensate(sample_t s);
        result_t     r;
        longint      ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        longint      x1, x2, x3, b3, b5, b6, b6sq, t, p, pr;
        logic [31:0] ac4, b4, b7, up;
        int          oss;
        ac1 = longint'($signed(coeff_word[REG_AC1_AC2][31:16]));
        ac2 = longint'($signed(coeff_word[REG_AC1_AC2][15:0]));
        ac3 = longint'($signed(coeff_word[REG_AC3_AC4][31:16]));
        ac4 = {16'd0, coeff_word[REG_AC3_AC4][15:0]};
        ac5 = longint'({48'd0, coeff_word[REG_AC5_AC6][31:16]});
        ac6 = longint'({48'd0, coeff_word[REG_AC5_AC6][15:0]});
        b1  = longint'($signed(coeff_word[REG_B1_B2][31:16]));
        b2  = longint'($signed(coeff_word[REG_B1_B2][15:0]));
        mc  = longint'($signed(coeff_word[REG_MC_MD][31:16]));
        md  = longint'($signed(coeff_word[REG_MC_MD][15:0]));
        oss = int'(coeff_word[REG_OVERSAMPLING][1:0]);
        ut  = longint'({48'd0, s.raw_temperature});
        up  = {13'd0, s.raw_pressure};
        r = '0;
        r.div_error = 1'b1;
        x1 = (ut - ac6) * ac5 / 32768;
        if (x1 + md == 0)
            return r;
        x2 = mc * 2048 / (x1 + md);
        b5 = x1 + x2;
        t = (b5 + 8) / 16;
        b6 = b5 - 4000;
        b6sq = floor_shift(b6 * b6, 12);
        x3 = floor_shift(b2 * b6sq, 11) + floor_shift(ac2 * b6, 11);
        b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
        x3 = floor_shift(floor_shift(ac3 * b6, 13) + floor_shift(b1 * b6sq, 16) + 2, 2);
        b4 = (ac4 * 32'(x3 + 32768)) >> 15;
        if (b4 == 0)
            return r;
        b7 = (up - 32'(b3)) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000)
            p = longint'({32'd0, (b7 * 32'd2) / b4});
        else
            p = longint'({32'd0, b7 / b4}) * 2;
        x1 = floor_shift(p, 8) * floor_shift(p, 8);
        x1 = floor_shift(x1 * 3038, 16);
        x2 = floor_shift(-7357 * p, 16);
        pr = p + floor_shift(x1 + x2 + 3791, 4);
        if (t < -32768) t = -32768;
        if (t > 32767) t = 32767;
        if (pr < 0) pr = 0;
        if (pr > 1048575) pr = 1048575;
        r.temperature_tenths = 16'(t);
        r.pressure_pa = 20'(pr);
        r.div_error = 1'b0;
        return r;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // sample driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample <= '0;
            send_gap <= 0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
                expected_results.push_back(compensate(sample));
            if (send_gap > 0)
            begin
                sample_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                sample_valid <= 1'b1;
                sample <= pending_samples.pop_front();
                send_gap <= gap_length();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result monitor
    int stall_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b1;
            stall_gap <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result %p", result);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    checked_count++;
                    if (e.div_error) error_count++;
                    if (result.temperature_tenths !== e.temperature_tenths)
                    begin
                        $error("temperature_tenths expected %0d got %0d",
                               e.temperature_tenths, result.temperature_tenths);
                        fail_count++;
                    end
                    if (result.pressure_pa !== e.pressure_pa)
                    begin
                        $error("pressure_pa expected %0d got %0d",
                               e.pressure_pa, result.pressure_pa);
                        fail_count++;
                    end
                    if (result.div_error !== e.div_error)
                    begin
                        $error("div_error expected %0b got %0b",
                               e.div_error, result.div_error);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_off_cycles <= hold_off_cycles - 1;
            end
            else if (stall_gap > 0)
            begin
                result_stall <= 1'b1;
                stall_gap <= stall_gap - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_gap <= gap_length();
            end
        end
    end

    // configuration writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            coeff_word[cfg_index] <= cfg_data;
        end
        else if (cfg_busy && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_next;
            cfg_data <= cfg_data_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("barometric_pressure_compensation_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_reg_next = idx;
        cfg_data_next = value;
        cfg_busy = 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        cfg_busy = 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // coefficient sets: a fixed sensor calibration, randomised plausible ones, field extremes or random words
    task automatic load_coeffs(int kind, logic [1:0] oss);
        if (kind == 0)
        begin
            write_reg(REG_AC1_AC2, {16'sd408, -16'sd72});
            write_reg(REG_AC3_AC4, {-16'sd14383, 16'd32741});
            write_reg(REG_AC5_AC6, {16'd32757, 16'd23153});
            write_reg(REG_B1_B2, {16'sd6190, 16'sd4});
            write_reg(REG_MC_MD, {-16'sd8711, 16'sd2868});
        end
        else if (kind == 1)
        begin
            write_reg(REG_AC1_AC2, {16'($urandom_range(0, 2000) + 7000), 16'($urandom)});
            write_reg(REG_AC3_AC4, {16'($urandom), 16'($urandom_range(20000, 40000))});
            write_reg(REG_AC5_AC6, {16'($urandom_range(20000, 40000)), 16'($urandom)});
            write_reg(REG_B1_B2, {16'($urandom), 16'($urandom_range(0, 200))});
            write_reg(REG_MC_MD, {16'($urandom), 16'($urandom_range(1000, 4000))});
        end
        else if (kind == 2)
        begin
            write_reg(REG_AC1_AC2, 32'h8000_7FFF);
            write_reg(REG_AC3_AC4, 32'h7FFF_FFFF);
            write_reg(REG_AC5_AC6, 32'hFFFF_FFFF);
            write_reg(REG_B1_B2, 32'h8000_7FFF);
            write_reg(REG_MC_MD, 32'h7FFF_8000);
        end
        else
        begin
            for (int i = 0; i < 5; i++)
                write_reg(cfg_reg_t'(i), $urandom);
        end
        write_reg(REG_OVERSAMPLING, {30'd0, oss});
    endtask

    task automatic random_samples(int n);
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            s.raw_temperature = $urandom_range(0, 5) == 0 ? 16'($urandom)
                                                          : 16'($urandom_range(20000, 35000));
            s.raw_pressure = $urandom_range(0, 5) == 0 ? 19'($urandom)
                                                       : 19'($urandom_range(20000, 100000));
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        sample_t s;
        rst_n = 1'b0;
        cfg_busy = 1'b0;
        hold_off_cycles = 0;
        fail_count = 0;
        checked_count = 0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < 6; i++)
            coeff_word[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: zero divisor everywhere
        s.raw_temperature = 16'hFFFF;
        s.raw_pressure = 19'h7FFFF;
        pending_samples.push_back(s);
        drain();

        // directed: field extremes, zero divisor via AC4 = 0 and via X1 + MD = 0
        load_coeffs(0, 2'd0);
        for (int b = 0; b < 16; b++)
        begin
            s.raw_temperature = 16'd1 << b;
            s.raw_pressure = 19'd1 << (b % 19);
            pending_samples.push_back(s);
        end
        pending_samples.push_back('0);
        pending_samples.push_back('1);
        pending_samples.push_back({16'd27898, 19'd23843});
        drain();
        write_reg(REG_AC3_AC4, 32'h0000_0000);
        pending_samples.push_back({16'd27898, 19'd23843});
        drain();
        write_reg(REG_AC5_AC6, 32'h0000_0000);
        write_reg(REG_MC_MD, 32'h0001_0000);
        write_reg(REG_AC3_AC4, 32'h0000_7FFF);
        pending_samples.push_back({16'd100, 19'd100});
        drain();
        load_coeffs(2, 2'd3);
        pending_samples.push_back('0);
        pending_samples.push_back('1);
        drain();

        // random phases across settings; the first one fills the pipeline behind a hold-off
        for (int phase = 0; phase < 8; phase++)
        begin
            load_coeffs(phase == 7 ? 3 : (phase % 3 == 2 ? 1 : phase % 2),
                        2'(phase % 4));
            if (phase == 0)
                hold_off_cycles = 300;
            random_samples(150);
            drain();
        end

        $display("checked %0d results over 8 coefficient settings, %0d divide errors",
                 checked_count, error_count);
        if (fail_count == 0)
            $display("barometric_pressure_compensation_test OK");
        else
            $display("barometric_pressure_compensation_test NOT OK");
        $finish;
    end
endmodule

// ----- barometric_pressure_compensation.f -----
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/bpc_temp.sv
sv/bpc_coef.sv
sv/bpc_pres.sv
sv/barometric_pressure_compensation.sv
dv/barometric_pressure_compensation_test.sv
